// ===== hdl/r2p_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_pkg
// Shared types and constants of the rectangular-to-polar converter.
// ----------------------------------------------------------------------------
package r2p_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF = 16;

  // fractional guard bits on the CORDIC x/y datapath
  localparam int GUARD_BITS = 8;
  // angle accumulator, units of pi/2^31
  localparam int Z_WIDTH = 33;

  // 1/K in Q32 and sqrt(2) in Q32
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
  localparam logic [63:0] SQRT2_Q32 = 64'd6074001000;

  // atan(2^-i) in units of pi/2^31, truncated
  localparam logic [31:0] ATAN_UNITS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
  };

  typedef enum logic [2:0] {
    RGN_RIGHT  = 3'd0,
    RGN_QUAD2  = 3'd1,
    RGN_QUAD3  = 3'd2,
    RGN_IMAG   = 3'd3,
    RGN_REAL   = 3'd4,
    RGN_ORIGIN = 3'd5
  } region_t;

  // sideband travelling alongside the CORDIC datapath
  typedef struct packed {
    region_t region;
    logic    neg;     // sign of the non-zero part on an axis
  } side_t;

endpackage

// ===== hdl/r2p_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_in_if
// Valid/ready channel carrying one complex sample.
// ----------------------------------------------------------------------------
interface r2p_in_if #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] real_part;
  logic signed [DATA_WIDTH-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

// ===== hdl/r2p_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_out_if
// Valid/ready channel carrying one polar result.
// ----------------------------------------------------------------------------
interface r2p_out_if #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic        [DATA_WIDTH-1:0] magnitude;
  logic signed [DATA_WIDTH:0]   angle;
  logic        [2:0]            region;

  modport source (output valid, output magnitude, output angle, output region, input ready);
  modport sink   (input valid, input magnitude, input angle, input region, output ready);
endinterface

// ===== hdl/r2p_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_prep
// Region classification and pre-rotation by pi into the right half plane.
// ----------------------------------------------------------------------------
module r2p_prep #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF,
  parameter int XW         = DATA_WIDTH + r2p_pkg::GUARD_BITS + 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [DATA_WIDTH-1:0]      real_part,
  input  logic signed [DATA_WIDTH-1:0]      imag_part,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [XW-1:0]              x_out,
  output logic signed [XW-1:0]              y_out,
  output logic signed [r2p_pkg::Z_WIDTH-1:0] z_out,
  output r2p_pkg::side_t                    side_out,
  output logic        [DATA_WIDTH-1:0]      amag_out
);

  localparam int G   = r2p_pkg::GUARD_BITS;
  localparam int PAD = XW - DATA_WIDTH - 1 - G;

  logic signed [DATA_WIDTH:0] re_ext, im_ext, abs_re, abs_im, y_pre;
  logic                       re_neg, im_neg, re_zero, im_zero;
  logic signed [XW-1:0]       x_next, y_next;
  r2p_pkg::side_t             side_next;
  logic [DATA_WIDTH-1:0]      amag_next;
  logic                       vld;

  always_comb begin
    re_ext  = {real_part[DATA_WIDTH-1], real_part};
    im_ext  = {imag_part[DATA_WIDTH-1], imag_part};
    re_neg  = real_part[DATA_WIDTH-1];
    im_neg  = imag_part[DATA_WIDTH-1];
    re_zero = (real_part == '0);
    im_zero = (imag_part == '0);
    abs_re  = re_neg ? -re_ext : re_ext;
    abs_im  = im_neg ? -im_ext : im_ext;
    y_pre   = re_neg ? -im_ext : im_ext;
    x_next  = {{PAD{1'b0}}, abs_re, {G{1'b0}}};
    y_next  = {{PAD{y_pre[DATA_WIDTH]}}, y_pre, {G{1'b0}}};

    if (!re_neg && !re_zero && !im_zero) begin
      side_next.region = r2p_pkg::RGN_RIGHT;
    end else if (re_neg && !im_neg && !im_zero) begin
      side_next.region = r2p_pkg::RGN_QUAD2;
    end else if (re_neg && im_neg) begin
      side_next.region = r2p_pkg::RGN_QUAD3;
    end else if (re_zero && !im_zero) begin
      side_next.region = r2p_pkg::RGN_IMAG;
    end else if (im_zero && !re_zero) begin
      side_next.region = r2p_pkg::RGN_REAL;
    end else begin
      side_next.region = r2p_pkg::RGN_ORIGIN;
    end
    side_next.neg = re_zero ? im_neg : re_neg;
    amag_next     = im_zero ? abs_re[DATA_WIDTH-1:0] : abs_im[DATA_WIDTH-1:0];
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= '0;
      side_out <= side_next;
      amag_out <= amag_next;
    end
  end

endmodule

// ===== hdl/r2p_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_cell
// One CORDIC vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module r2p_cell #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF,
  parameter int XW         = DATA_WIDTH + r2p_pkg::GUARD_BITS + 3,
  parameter int SHIFT      = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [XW-1:0]               x_in,
  input  logic signed [XW-1:0]               y_in,
  input  logic signed [r2p_pkg::Z_WIDTH-1:0] z_in,
  input  r2p_pkg::side_t                     side_in,
  input  logic        [DATA_WIDTH-1:0]       amag_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [XW-1:0]               x_out,
  output logic signed [XW-1:0]               y_out,
  output logic signed [r2p_pkg::Z_WIDTH-1:0] z_out,
  output r2p_pkg::side_t                     side_out,
  output logic        [DATA_WIDTH-1:0]       amag_out
);

  localparam int ZW = r2p_pkg::Z_WIDTH;
  localparam logic signed [ZW-1:0] STEP = ZW'(r2p_pkg::ATAN_UNITS[SHIFT]);

  logic signed [XW-1:0] dx, dy, x_next, y_next;
  logic signed [ZW-1:0] z_next;
  logic                 vld;

  always_comb begin
    dx = y_in >>> SHIFT;
    dy = x_in >>> SHIFT;
    if (!y_in[XW-1]) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + STEP;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - STEP;
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
      amag_out <= amag_in;
    end
  end

endmodule

// ===== hdl/r2p_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_post
// Gain compensation, angle rounding and quadrant offset, special-case
// selection. Two register stages; the second is the output register.
// ----------------------------------------------------------------------------
module r2p_post #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF,
  parameter int XW         = DATA_WIDTH + r2p_pkg::GUARD_BITS + 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [XW-1:0]               x_in,
  input  logic signed [r2p_pkg::Z_WIDTH-1:0] z_in,
  input  r2p_pkg::side_t                     side_in,
  input  logic        [DATA_WIDTH-1:0]       amag_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [DATA_WIDTH-1:0]       magnitude,
  output logic signed [DATA_WIDTH:0]         angle,
  output logic        [2:0]                  region
);

  localparam int ZW  = r2p_pkg::Z_WIDTH;
  localparam int G   = r2p_pkg::GUARD_BITS;
  localparam int SH  = 32 - DATA_WIDTH;
  localparam int AW  = ZW + 2;
  localparam int HW  = XW - 16;
  localparam int PLW = 48;
  localparam int PHW = HW + 32;
  localparam int PW  = XW + 32;
  localparam int MW  = XW + 1;

  localparam logic signed [ZW-1:0] RND     = (ZW'(1) << SH) >>> 1;
  localparam logic signed [AW-1:0] HALF    = AW'(1) << (DATA_WIDTH - 1);
  localparam logic signed [AW-1:0] QUARTER = AW'(1) << (DATA_WIDTH - 2);
  localparam logic [63:0] CAP_FULL =
    (r2p_pkg::SQRT2_Q32 << (DATA_WIDTH - 1)) + 64'h8000_0000;
  localparam logic [MW-1:0] MAG_CAP = MW'(CAP_FULL[63:32]);
  localparam logic [MW-1:0] MAG_RND = MW'(1) << (G - 1);

  // stage 1
  logic signed [ZW-1:0] z_rnd;
  logic signed [AW-1:0] a_base, a_sum, a_sel;
  logic [PLW-1:0]       p_lo, p_lo_next;
  logic [PHW-1:0]       p_hi, p_hi_next;
  logic signed [DATA_WIDTH:0] ang1;
  r2p_pkg::side_t       side1;
  logic [DATA_WIDTH-1:0] amag1;
  logic                 v1, rdy1;

  // stage 2
  logic [PW-1:0]        p_sum;
  logic [MW-1:0]        t_val, m_rnd, m_cap;
  logic [DATA_WIDTH-1:0] mag_next;
  logic                 v2, rdy2;

  always_comb begin
    z_rnd     = (z_in + RND) >>> SH;
    a_base    = AW'(z_rnd);
    a_sum     = a_base;
    a_sel     = '0;
    p_lo_next = PLW'(x_in[15:0]) * PLW'(r2p_pkg::INV_GAIN_Q32);
    p_hi_next = PHW'(x_in[XW-1:16]) * PHW'(r2p_pkg::INV_GAIN_Q32);
    case (side_in.region)
      r2p_pkg::RGN_QUAD2: a_sum = a_base + HALF;
      r2p_pkg::RGN_QUAD3: a_sum = a_base - HALF;
      default:            a_sum = a_base;
    endcase
    case (side_in.region)
      r2p_pkg::RGN_RIGHT, r2p_pkg::RGN_QUAD2, r2p_pkg::RGN_QUAD3: begin
        if (a_sum > HALF) begin
          a_sel = HALF;
        end else if (a_sum < -HALF) begin
          a_sel = -HALF;
        end else begin
          a_sel = a_sum;
        end
      end
      r2p_pkg::RGN_IMAG: a_sel = side_in.neg ? -QUARTER : QUARTER;
      r2p_pkg::RGN_REAL: a_sel = side_in.neg ? HALF : '0;
      default:           a_sel = '0;
    endcase
  end

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      p_lo  <= p_lo_next;
      p_hi  <= p_hi_next;
      ang1  <= a_sel[DATA_WIDTH:0];
      side1 <= side_in;
      amag1 <= amag_in;
    end
  end

  always_comb begin
    p_sum = (PW'(p_hi) << 16) + PW'(p_lo);
    t_val = MW'(p_sum[PW-1:32]);
    m_rnd = (t_val + MAG_RND) >> G;
    m_cap = (m_rnd > MAG_CAP) ? MAG_CAP : m_rnd;
    case (side1.region)
      r2p_pkg::RGN_IMAG, r2p_pkg::RGN_REAL: mag_next = amag1;
      r2p_pkg::RGN_ORIGIN:                  mag_next = '0;
      default:                              mag_next = m_cap[DATA_WIDTH-1:0];
    endcase
  end

  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      magnitude <= mag_next;
      angle     <= ang1;
      region    <= side1.region;
    end
  end

endmodule

// ===== hdl/rect_to_polar_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_to_polar_unit
// Complex sample to magnitude, four-quadrant angle and region code through
// a chain of CORDIC vectoring cells.
//
//   channel  role  payload
//   sample   sink  real_part, imag_part      (signed DATA_WIDTH)
//   polar    src   magnitude (DATA_WIDTH), angle (signed DATA_WIDTH+1), region (3)
//
// One transaction per clock in and out when the sink keeps ready high.
// Registers in order: prep register, one register per cell, two
// post stages. Each stage holds its transaction while the next is full;
// ready ripples back through the chain, so bubbles are absorbed.
// Synchronous reset clears the valid flags only.
// ----------------------------------------------------------------------------
module rect_to_polar_unit #(
  parameter int DATA_WIDTH = r2p_pkg::DATA_WIDTH_DEF,
  parameter int ITERATIONS = r2p_pkg::ITERATIONS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  r2p_in_if.sink   sample,
  r2p_out_if.source polar
);

  localparam int XW = DATA_WIDTH + r2p_pkg::GUARD_BITS + 3;
  localparam int ZW = r2p_pkg::Z_WIDTH;
  localparam logic signed [DATA_WIDTH:0] HALF_TURN    = (DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1);
  localparam logic signed [DATA_WIDTH:0] QUARTER_TURN = (DATA_WIDTH+1)'(1) << (DATA_WIDTH - 2);
  localparam logic [63:0] CAP_FULL =
    (r2p_pkg::SQRT2_Q32 << (DATA_WIDTH - 1)) + 64'h8000_0000;
  localparam logic [DATA_WIDTH-1:0] MAG_CAP = DATA_WIDTH'(CAP_FULL[63:32]);

  logic                  c_valid [ITERATIONS+1];
  logic                  c_ready [ITERATIONS+1];
  logic signed [XW-1:0]  c_x     [ITERATIONS+1];
  logic signed [XW-1:0]  c_y     [ITERATIONS+1];
  logic signed [ZW-1:0]  c_z     [ITERATIONS+1];
  r2p_pkg::side_t        c_side  [ITERATIONS+1];
  logic [DATA_WIDTH-1:0] c_amag  [ITERATIONS+1];

  r2p_prep #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .real_part (sample.real_part),
    .imag_part (sample.imag_part),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .x_out     (c_x[0]),
    .y_out     (c_y[0]),
    .z_out     (c_z[0]),
    .side_out  (c_side[0]),
    .amag_out  (c_amag[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    r2p_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .XW         (XW),
      .SHIFT      (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .x_in      (c_x[i]),
      .y_in      (c_y[i]),
      .z_in      (c_z[i]),
      .side_in   (c_side[i]),
      .amag_in   (c_amag[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .x_out     (c_x[i+1]),
      .y_out     (c_y[i+1]),
      .z_out     (c_z[i+1]),
      .side_out  (c_side[i+1]),
      .amag_out  (c_amag[i+1])
    );
  end

  r2p_post #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[ITERATIONS]),
    .in_ready  (c_ready[ITERATIONS]),
    .x_in      (c_x[ITERATIONS]),
    .z_in      (c_z[ITERATIONS]),
    .side_in   (c_side[ITERATIONS]),
    .amag_in   (c_amag[ITERATIONS]),
    .out_valid (polar.valid),
    .out_ready (polar.ready),
    .magnitude (polar.magnitude),
    .angle     (polar.angle),
    .region    (polar.region)
  );

  // origin result has zero magnitude and zero angle
  a_origin: assert property (@(posedge clk) disable iff (rst)
    polar.valid && polar.region == r2p_pkg::RGN_ORIGIN |->
      polar.magnitude == '0 && polar.angle == '0)
    else $error("origin result not zero");

  // angle never leaves the closed half-turn range
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    polar.valid |-> polar.angle <= HALF_TURN && polar.angle >= -HALF_TURN)
    else $error("angle out of range");

  // magnitude saturates at the diagonal cap
  a_mag_cap: assert property (@(posedge clk) disable iff (rst)
    polar.valid |-> polar.magnitude <= MAG_CAP)
    else $error("magnitude above cap");

  // imaginary axis gives exactly plus or minus a quarter turn
  a_imag_axis: assert property (@(posedge clk) disable iff (rst)
    polar.valid && polar.region == r2p_pkg::RGN_IMAG |->
      polar.angle == QUARTER_TURN || polar.angle == -QUARTER_TURN)
    else $error("imaginary-axis angle wrong");

endmodule
